// ===== hdl/spl_pkg.sv =====
`default_nettype none

package spl_pkg;

	localparam int DEPTH_DEF     = 32;
	localparam int KEY_WIDTH_DEF = 16;
	localparam int FIELD_W       = 16;
	localparam int FUNC_W        = 2;
	localparam int COUNT_OUT_W   = 6;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd3;

	// register index as decoded from paddr[2]
	localparam logic REG_SORT = 1'b0;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_SH_M1,
		RD_IDX_P1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_SH_RD,
		WR_IDX_RD,
		WR_IDX_NEW
	} wr_sel_t;

	typedef struct packed {
		logic [FIELD_W-1:0] node;
		logic [FIELD_W-1:0] cost;
		logic [FIELD_W-1:0] est;
	} rec_t;

	typedef struct packed {
		logic    load;
		logic    idx_inc;
		logic    sh_load;
		logic    sh_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    capture;
	} cmd_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic              last;
		logic              sh_at_pos;
		logic              key_le;
		logic              match;
		logic [FUNC_W-1:0] op;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_priority_list_core.sv =====
`default_nettype none

// Channel   Signals                                              Handshake
// request   start, func, node_id, cost_so_far, estimated_total   start & !busy
// result    found, out_node_id, out_cost_so_far,                 done, one cycle
//           out_estimated_total, list_full, entry_count
// config    psel, penable, pwrite, paddr, pwdata, prdata         APB, pready tied high
//
// One request at a time; the list sits in a single-port-read memory walked one entry
// at a time (registered read, then compare or write); insert shifts later entries
// down, remove shifts them up. A full-list insert or an empty-list find, remove or peek
// finishes at acceptance without touching memory. done pulses the cycle after the last step.
// Reset empties the list and sets sort_by_estimate; memory contents need no clearing.
// The receiver cannot stall; busy holds off new requests while one is in flight.

module sorted_priority_list_core #(
	parameter int DEPTH     = spl_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = spl_pkg::KEY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [spl_pkg::FUNC_W-1:0]      func,
	input  logic [spl_pkg::FIELD_W-1:0]     node_id,
	input  logic [spl_pkg::FIELD_W-1:0]     cost_so_far,
	input  logic [spl_pkg::FIELD_W-1:0]     estimated_total,
	output logic                            done,
	output logic                            found,
	output logic [spl_pkg::FIELD_W-1:0]     out_node_id,
	output logic [spl_pkg::FIELD_W-1:0]     out_cost_so_far,
	output logic [spl_pkg::FIELD_W-1:0]     out_estimated_total,
	output logic                            list_full,
	output logic [spl_pkg::COUNT_OUT_W-1:0] entry_count,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spl_pkg::ADDR_W-1:0]      paddr,
	input  logic [spl_pkg::DATA_W-1:0]      pwdata,
	output logic [spl_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import spl_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic sort_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SORT) begin
			sort_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_SORT) ? DATA_W'(sort_q) : '0;

	spl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	spl_dp #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.sort_by_estimate    (sort_q),
		.func                (func),
		.node_id             (node_id),
		.cost_so_far         (cost_so_far),
		.estimated_total     (estimated_total),
		.found               (found),
		.out_node_id         (out_node_id),
		.out_cost_so_far     (out_cost_so_far),
		.out_estimated_total (out_estimated_total),
		.list_full           (list_full),
		.entry_count         (entry_count)
	);

endmodule

`default_nettype wire

// ===== hdl/spl_dp.sv =====
`default_nettype none

module spl_dp #(
	parameter int DEPTH     = spl_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = spl_pkg::KEY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spl_pkg::cmd_t                   cmd,
	output spl_pkg::sts_t                   sts,
	input  logic                            sort_by_estimate,
	input  logic [spl_pkg::FUNC_W-1:0]      func,
	input  logic [spl_pkg::FIELD_W-1:0]     node_id,
	input  logic [spl_pkg::FIELD_W-1:0]     cost_so_far,
	input  logic [spl_pkg::FIELD_W-1:0]     estimated_total,
	output logic                            found,
	output logic [spl_pkg::FIELD_W-1:0]     out_node_id,
	output logic [spl_pkg::FIELD_W-1:0]     out_cost_so_far,
	output logic [spl_pkg::FIELD_W-1:0]     out_estimated_total,
	output logic                            list_full,
	output logic [spl_pkg::COUNT_OUT_W-1:0] entry_count
);
	import spl_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	rec_t              mem [DEPTH];
	rec_t              rd_q;
	rec_t              new_q;
	rec_t              res_q;
	rec_t              wdata;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     sh_q;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [CW-1:0]     count_q;
	logic [FUNC_W-1:0] op_q;
	logic              hit_q;
	logic              full_q;
	logic [KEY_WIDTH-1:0] key_new;
	logic [KEY_WIDTH-1:0] key_rd;

	function automatic logic [KEY_WIDTH-1:0] key_of(input logic sel, input rec_t r);
		return sel ? KEY_WIDTH'(r.est) : KEY_WIDTH'(r.cost);
	endfunction

	assign key_new = key_of(sort_by_estimate, new_q);
	assign key_rd  = key_of(sort_by_estimate, rd_q);

	always_comb begin
		case (cmd.rd_sel)
			RD_SH_M1:  raddr = sh_q - AW'(1);
			RD_IDX_P1: raddr = idx_q + AW'(1);
			default:   raddr = idx_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_SH_RD: begin
				waddr = sh_q;
				wdata = rd_q;
			end
			WR_IDX_RD: begin
				waddr = idx_q;
				wdata = rd_q;
			end
			default: begin
				waddr = idx_q;
				wdata = new_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[waddr] <= wdata;
		if (cmd.rd_en)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q.node <= node_id;
			new_q.cost <= cost_so_far;
			new_q.est  <= estimated_total;
			res_q      <= '0;
		end else if (cmd.capture) begin
			res_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			sh_q    <= '0;
			op_q    <= FUNC_INSERT;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				op_q   <= func;
				idx_q  <= '0;
				hit_q  <= 1'b0;
				full_q <= (func == FUNC_INSERT) && (count_q == DEPTH_C);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.capture)
				hit_q <= 1'b1;
			// insert only runs below capacity, so count fits the index width
			if (cmd.sh_load)
				sh_q <= AW'(count_q);
			else if (cmd.sh_dec)
				sh_q <= sh_q - AW'(1);
			if (cmd.cnt_inc)
				count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec)
				count_q <= count_q - CW'(1);
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == DEPTH_C);
	assign sts.last      = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.sh_at_pos = (sh_q == idx_q);
	assign sts.key_le    = (key_new <= key_rd);
	assign sts.match     = (rd_q.node == new_q.node);
	assign sts.op        = op_q;

	assign found               = hit_q;
	assign out_node_id         = res_q.node;
	assign out_cost_so_far     = res_q.cost;
	assign out_estimated_total = res_q.est;
	assign list_full           = full_q;
	assign entry_count         = COUNT_OUT_W'(count_q);

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");
	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q != DEPTH_C)
		else $error("insert committed on a full list");
	a_dec_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (count_q != '0) && hit_q && (op_q == FUNC_REMOVE))
		else $error("remove committed without a matched entry");
`endif

endmodule

`default_nettype wire

// ===== hdl/spl_ctrl.sv =====
`default_nettype none

module spl_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [spl_pkg::FUNC_W-1:0] func,
	input  spl_pkg::sts_t              sts,
	output spl_pkg::cmd_t              cmd,
	output logic                       busy,
	output logic                       done
);
	import spl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SHD_RD,
		ST_SHD_WR,
		ST_INS_WR,
		ST_SHU_RD,
		ST_SHU_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   finish;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (func == FUNC_INSERT) begin
						if (sts.full)
							finish = 1'b1;
						else if (sts.empty)
							state_d = ST_INS_WR;
						else
							state_d = ST_SCAN_RD;
					end else if (sts.empty) begin
						finish = 1'b1;
					end else begin
						state_d = ST_SCAN_RD;
					end
				end
			end
			ST_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (sts.op == FUNC_INSERT) begin
					if (sts.key_le) begin
						cmd.sh_load = 1'b1;
						state_d     = ST_SHD_RD;
					end else begin
						// key sorts after this entry: move to idx + 1, appending there if this entry was the tail
						cmd.idx_inc = 1'b1;
						state_d     = sts.last ? ST_INS_WR : ST_SCAN_RD;
					end
				end else if (sts.match || sts.op == FUNC_PEEK) begin
					cmd.capture = 1'b1;
					if (sts.op == FUNC_REMOVE) begin
						state_d = ST_SHU_RD;
					end else begin
						state_d = ST_IDLE;
						finish  = 1'b1;
					end
				end else if (sts.last) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_SHD_RD: begin
				if (sts.sh_at_pos) begin
					state_d = ST_INS_WR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_SH_M1;
					state_d    = ST_SHD_WR;
				end
			end
			ST_SHD_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SH_RD;
				cmd.sh_dec = 1'b1;
				state_d    = ST_SHD_RD;
			end
			ST_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_IDX_NEW;
				cmd.cnt_inc = 1'b1;
				state_d     = ST_IDLE;
				finish      = 1'b1;
			end
			ST_SHU_RD: begin
				if (sts.last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = ST_IDLE;
					finish      = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_P1;
					state_d    = ST_SHU_WR;
				end
			end
			ST_SHU_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_IDX_RD;
				cmd.idx_inc = 1'b1;
				state_d     = ST_SHU_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
			done_q  <= finish;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

`ifndef ASSERT_OFF
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy out of step with state");
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (busy_q || done_q))
		else $error("accepted request neither running nor finished");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while still busy");
`endif

endmodule

`default_nettype wire
